// ===== rtl/core/ptfm_pkg.sv =====
// Shared constants for the pedestal/threshold pipeline.
package ptfm_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int FRAC_BITS  = 8;    // fraction bits of mean/sigma
    localparam int HALF_BITS  = 9;    // width of each packed half
    localparam int FIELD_BITS = 20;   // width of mean/sigma outputs
    localparam int CUT_BITS   = 16;   // sigma_cut register width
    localparam int THR_BITS   = CUT_BITS + HALF_BITS; // bits of the threshold sum kept
    localparam int MUL_DIGIT  = 16;   // multiplier digit per pipeline stage

    localparam logic [CUT_BITS-1:0] SIGMA_CUT_RESET = 16'd1024; // 4.0 in 8.8

endpackage

// ===== rtl/core/ptfm_mul.sv =====
// Pipelined multiplier, one 16-bit digit of the b operand per stage.
module ptfm_mul #(
    parameter int AW     = 48,
    parameter int BW     = 24,
    parameter int STAGES = 3,
    parameter int SW     = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [AW-1:0]     i_a,
    input  logic [BW-1:0]     i_b,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [AW+BW-1:0]  o_prod,
    output logic [SW-1:0]     o_side
);
    import ptfm_pkg::*;

    localparam int PW  = AW + BW;
    localparam int BPW = STAGES * MUL_DIGIT;

    logic            r_v    [0:STAGES];
    logic [AW-1:0]   r_a    [0:STAGES];
    logic [BPW-1:0]  r_b    [0:STAGES];
    logic [PW-1:0]   r_acc  [0:STAGES];
    logic [SW-1:0]   r_side [0:STAGES];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < STAGES; k++) r_v[k+1] <= r_v[k];
        end
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        r_a[0]    <= i_a;
        r_b[0]    <= BPW'(i_b);
        r_acc[0]  <= '0;
        r_side[0] <= i_side;
    end

    // one partial product and accumulate per stage
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [AW+MUL_DIGIT-1:0] w_pp;
        logic [PW-1:0]           n_acc;

        assign w_pp  = r_a[k] * r_b[k][k*MUL_DIGIT +: MUL_DIGIT];
        assign n_acc = r_acc[k] + (PW'(w_pp) << (k*MUL_DIGIT));

        always_ff @(posedge i_clk) begin
            r_a[k+1]    <= r_a[k];
            r_b[k+1]    <= r_b[k];
            r_acc[k+1]  <= n_acc;
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_prod  = r_acc[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ===== rtl/core/ptfm_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module ptfm_isqrt #(
    parameter int XW = 88,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [XW-1:0]      i_x,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [XW/2-1:0]    o_root,
    output logic [SW-1:0]      o_side
);
    localparam int RW = XW / 2;

    logic           r_v    [0:RW];
    logic [XW-1:0]  r_x    [0:RW];
    logic [RW:0]    r_rem  [0:RW];
    logic [RW-1:0]  r_root [0:RW];
    logic [SW-1:0]  r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RW; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < RW; k++) r_v[k+1] <= r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= i_x;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    // bring down two radicand bits, try root*4+1
    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RW+2:0] w_remx;
        logic [RW+2:0] w_trial;
        logic          w_ge;
        logic [RW:0]   n_rem;

        assign w_remx  = {r_rem[k], r_x[k][XW-1 -: 2]};
        assign w_trial = {1'b0, r_root[k], 2'b01};
        assign w_ge    = (w_remx >= w_trial);
        assign n_rem   = w_ge ? (RW+1)'(w_remx - w_trial) : (RW+1)'(w_remx);

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= r_x[k] << 2;
            r_rem[k+1]  <= n_rem;
            r_root[k+1] <= {r_root[k][RW-2:0], w_ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

// ===== rtl/core/ptfm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ptfm_div #(
    parameter int NW  = 44,
    parameter int DVW = 24,
    parameter int SW  = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [DVW-1:0]  i_den,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [NW-1:0]   o_quot,
    output logic [SW-1:0]   o_side
);
    logic            r_v    [0:NW];
    logic [NW-1:0]   r_num  [0:NW];
    logic [DVW-1:0]  r_den  [0:NW];
    logic [DVW-1:0]  r_rem  [0:NW];
    logic [NW-1:0]   r_quot [0:NW];
    logic [SW-1:0]   r_side [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NW; k++) r_v[k+1] <= r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_rem[0]  <= '0;
        r_quot[0] <= '0;
        r_side[0] <= i_side;
    end

    // shift in next numerator bit, subtract divisor if it fits
    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DVW:0]   w_remx;
        logic           w_ge;
        logic [DVW-1:0] n_rem;

        assign w_remx = {r_rem[k], r_num[k][NW-1]};
        assign w_ge   = (w_remx >= {1'b0, r_den[k]});
        assign n_rem  = w_ge ? DVW'(w_remx - {1'b0, r_den[k]}) : DVW'(w_remx);

        always_ff @(posedge i_clk) begin
            r_num[k+1]  <= r_num[k] << 1;
            r_den[k+1]  <= r_den[k];
            r_rem[k+1]  <= n_rem;
            r_quot[k+1] <= {r_quot[k][NW-2:0], w_ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[NW];
    assign o_quot  = r_quot[NW];
    assign o_side  = r_side[NW];

endmodule

// ===== rtl/core/pedestal_threshold_from_moments.sv =====
// Top level: channel pedestal, sigma and threshold from accumulated moments.
//
//  channel   | signals                                   | direction | flow control
//  ----------+-------------------------------------------+-----------+--------------
//  command   | start, busy, i_sample_count/charge/square | in        | start & !busy
//  result    | o_done, o_packed_word/mean/sigma_fixed    | out       | strobe only
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data      | in        | valid & ready
//
//  One channel is taken every cycle; busy stays low. The pipeline has
//  MS = ceil((COUNT_BITS+SAMPLE_BITS)/16) multiplier stages and
//  RW = COUNT_BITS+SAMPLE_BITS+8 stages each for square root and divide.
//  Reset clears all valid bits and loads sigma_cut with 4.0.
//  The result strobe lasts one cycle; the receiver has no way to stall the pipeline.
module pedestal_threshold_from_moments #(
    parameter int COUNT_BITS  = ptfm_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = ptfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [COUNT_BITS-1:0]                  i_sample_count,
    input  logic [COUNT_BITS+SAMPLE_BITS-1:0]      i_charge_sum,
    input  logic [COUNT_BITS+2*SAMPLE_BITS-1:0]    i_square_sum,
    output logic                                   o_done,
    output logic [2*ptfm_pkg::HALF_BITS-1:0]       o_packed_word,
    output logic [ptfm_pkg::FIELD_BITS-1:0]        o_mean_fixed,
    output logic [ptfm_pkg::FIELD_BITS-1:0]        o_sigma_fixed,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ptfm_pkg::CUT_BITS-1:0]          i_cfg_data
);
    import ptfm_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int SW = COUNT_BITS + SAMPLE_BITS;
    localparam int QW = COUNT_BITS + 2*SAMPLE_BITS;
    localparam int DW = 2*SW;
    localparam int XW = DW + 2*FRAC_BITS;
    localparam int RW = XW / 2;
    localparam int MS = (SW + MUL_DIGIT - 1) / MUL_DIGIT;

    logic [CUT_BITS-1:0] r_cut;

    // sigma_cut register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= SIGMA_CUT_RESET;
        end else if (i_cfg_valid) begin
            r_cut <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // N*Q and S*S
    logic              w_nq_v;
    logic [DW-1:0]     w_nq;
    logic [CB+SW-1:0]  w_nq_side;
    logic [DW-1:0]     w_ss;

    ptfm_mul #(.AW(QW), .BW(CB), .STAGES(MS), .SW(CB+SW)) u_mul_nq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start & ~busy),
        .i_a(i_square_sum), .i_b(i_sample_count), .i_side({i_sample_count, i_charge_sum}),
        .o_valid(w_nq_v), .o_prod(w_nq), .o_side(w_nq_side)
    );

    ptfm_mul #(.AW(SW), .BW(SW), .STAGES(MS), .SW(1)) u_mul_ss (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start & ~busy),
        .i_a(i_charge_sum), .i_b(i_charge_sum), .i_side(1'b0),
        .o_valid(), .o_prod(w_ss), .o_side()
    );

    // |N*Q - S*S|
    logic              r_d_v;
    logic [DW-1:0]     r_d;
    logic [CB+SW-1:0]  r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= w_nq_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r_d      <= (w_nq >= w_ss) ? (w_nq - w_ss) : (w_ss - w_nq);
        r_d_side <= w_nq_side;
    end

    // root of the variance term scaled by 2^16
    logic              w_rt_v;
    logic [RW-1:0]     w_root;
    logic [CB+SW-1:0]  w_rt_side;
    logic [CB-1:0]     w_rt_n;
    logic [SW-1:0]     w_rt_s;

    ptfm_isqrt #(.XW(XW), .SW(CB+SW)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_d_v),
        .i_x({r_d, {(2*FRAC_BITS){1'b0}}}), .i_side(r_d_side),
        .o_valid(w_rt_v), .o_root(w_root), .o_side(w_rt_side)
    );
    assign w_rt_n = w_rt_side[CB+SW-1:SW];
    assign w_rt_s = w_rt_side[SW-1:0];

    // sigma and mean in 8-fraction-bit fixed point
    logic           w_dv_v;
    logic [RW-1:0]  w_sig;
    logic [RW-1:0]  w_mean;
    logic           w_zero;

    ptfm_div #(.NW(RW), .DVW(CB), .SW(1)) u_div_sig (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_rt_v),
        .i_num(w_root), .i_den(w_rt_n), .i_side(w_rt_n == '0),
        .o_valid(w_dv_v), .o_quot(w_sig), .o_side(w_zero)
    );

    ptfm_div #(.NW(RW), .DVW(CB), .SW(1)) u_div_mean (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_rt_v),
        .i_num({w_rt_s, {FRAC_BITS{1'b0}}}), .i_den(w_rt_n), .i_side(1'b0),
        .o_valid(), .o_quot(w_mean), .o_side()
    );

    // sigma * cut, low bits only
    logic [RW+THR_BITS-1:0] w_sig_ext;
    logic                   r_t1_v;
    logic                   r_t1_zero;
    logic [THR_BITS-1:0]    r_t1_prod;
    logic [FIELD_BITS-1:0]  r_t1_mean;
    logic [FIELD_BITS-1:0]  r_t1_sig;

    assign w_sig_ext = {{THR_BITS{1'b0}}, w_sig};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else begin
            r_t1_v <= w_dv_v;
        end
    end
    always_ff @(posedge i_clk) begin
        r_t1_zero <= w_zero;
        r_t1_prod <= THR_BITS'(w_sig_ext[THR_BITS-1:0] * r_cut);
        r_t1_mean <= w_mean[FIELD_BITS-1:0];
        r_t1_sig  <= w_sig[FIELD_BITS-1:0];
    end

    // threshold add and result register
    logic [THR_BITS-1:0]      w_sum;
    logic                     r_done;
    logic [2*HALF_BITS-1:0]   r_packed;
    logic [FIELD_BITS-1:0]    r_mean;
    logic [FIELD_BITS-1:0]    r_sig;

    assign w_sum = r_t1_prod
                 + {r_t1_mean[THR_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_t1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_t1_zero) begin
            r_packed <= '0;
            r_mean   <= '0;
            r_sig    <= '0;
        end else begin
            r_packed <= {w_sum[CUT_BITS +: HALF_BITS], r_t1_mean[FRAC_BITS +: HALF_BITS]};
            r_mean   <= r_t1_mean;
            r_sig    <= r_t1_sig;
        end
    end

    assign o_done        = r_done;
    assign o_packed_word = r_packed;
    assign o_mean_fixed  = r_mean;
    assign o_sigma_fixed = r_sig;

endmodule

// ===== rtl/core/ptfm_checker.sv =====
// Port-level checks for the pedestal/threshold pipeline, bound to the top level.
module ptfm_checker #(
    parameter int COUNT_BITS  = ptfm_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = ptfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [COUNT_BITS-1:0]                  i_sample_count,
    input  logic [COUNT_BITS+SAMPLE_BITS-1:0]      i_charge_sum,
    input  logic [COUNT_BITS+2*SAMPLE_BITS-1:0]    i_square_sum,
    input  logic                                   o_done,
    input  logic [2*ptfm_pkg::HALF_BITS-1:0]       o_packed_word,
    input  logic [ptfm_pkg::FIELD_BITS-1:0]        o_mean_fixed,
    input  logic [ptfm_pkg::FIELD_BITS-1:0]        o_sigma_fixed,
    input  logic                                   i_cfg_valid,
    input  logic                                   o_cfg_ready,
    input  logic [ptfm_pkg::CUT_BITS-1:0]          i_cfg_data
);
    import ptfm_pkg::*;

    localparam int SW  = COUNT_BITS + SAMPLE_BITS;
    localparam int RW  = SW + FRAC_BITS;
    localparam int MS  = (SW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LAT = MS + 2*RW + 6;

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result strobe missing after accepted transaction");

    // no result without a matching transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without transaction");

    // zero count gives all-zero result
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_sample_count == '0) |-> ##LAT
        (o_packed_word == '0 && o_mean_fixed == '0 && o_sigma_fixed == '0))
        else $error("zero count gave nonzero result");

    // pedestal half is the integer part of the mean
    a_pedestal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_packed_word[HALF_BITS-1:0] == o_mean_fixed[FRAC_BITS +: HALF_BITS]))
        else $error("pedestal does not match mean");

endmodule

bind pedestal_threshold_from_moments ptfm_checker #(
    .COUNT_BITS(COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_ptfm_checker (.*);

// ===== tb/pedestal_threshold_from_moments_checker.sv =====
// Checker for the pedestal/threshold block: predicts each channel's result and compares.
module pedestal_threshold_from_moments_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [23:0]                       i_sample_count,
    input  logic [35:0]                       i_charge_sum,
    input  logic [47:0]                       i_square_sum,
    input  logic                              o_done,
    input  logic [2*ptfm_pkg::HALF_BITS-1:0]  o_packed_word,
    input  logic [ptfm_pkg::FIELD_BITS-1:0]   o_mean_fixed,
    input  logic [ptfm_pkg::FIELD_BITS-1:0]   o_sigma_fixed,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [ptfm_pkg::CUT_BITS-1:0]     i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ptfm_pkg::*;

    typedef struct packed {
        logic [2*HALF_BITS-1:0] packed_word;
        logic [FIELD_BITS-1:0]  mean_fixed;
        logic [FIELD_BITS-1:0]  sigma_fixed;
    } t_chan_result;

    t_chan_result        result_q[$];
    logic [CUT_BITS-1:0] cut_copy;
    int                  fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    // integer square root, floor
    function automatic logic [63:0] root_floor(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (x >= sq) r = c;
        end
        return r;
    endfunction

    function automatic t_chan_result channel_result(input logic [23:0] n_in,
                                                    input logic [35:0] s_in,
                                                    input logic [47:0] q_in,
                                                    input logic [CUT_BITS-1:0] cut);
        t_chan_result  r;
        logic [127:0]  nq;
        logic [127:0]  ss;
        logic [127:0]  diff;
        logic [63:0]   rt;
        logic [63:0]   sig256;
        logic [63:0]   mean256;
        logic [63:0]   ped;
        logic [63:0]   thr;
        r = '0;
        if (n_in == 0) return r;
        nq = 128'(n_in) * 128'(q_in);
        ss = 128'(s_in) * 128'(s_in);
        // variance may come out negative; take its magnitude
        diff = (nq < ss) ? ss - nq : nq - ss;
        rt      = root_floor(diff << 16);
        sig256  = rt / 64'(n_in);
        mean256 = (64'(s_in) << FRAC_BITS) / 64'(n_in);
        ped     = 64'(s_in) / 64'(n_in);
        thr     = ((sig256 * 64'(cut) + (mean256 << FRAC_BITS)) >> 16) & 64'h1FF;
        r.packed_word = {thr[HALF_BITS-1:0], ped[HALF_BITS-1:0]};
        r.mean_fixed  = mean256[FIELD_BITS-1:0];
        r.sigma_fixed = sig256[FIELD_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_chan_result want;
        if (!i_rst_n) begin
            cut_copy = SIGMA_CUT_RESET;
            result_q.delete();
        end else begin
            // config transaction
            if (i_cfg_valid && o_cfg_ready) cut_copy = i_cfg_data;
            // command transaction
            if (start && !busy)
                result_q.push_back(channel_result(i_sample_count, i_charge_sum,
                                                  i_square_sum, cut_copy));
            // result transaction
            if (o_done) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_packed_word), 64'd0);
                end else begin
                    want = result_q.pop_front();
                    if (o_packed_word !== want.packed_word)
                        report_mismatch("packed_word", 64'(o_packed_word),
                                        64'(want.packed_word));
                    if (o_mean_fixed !== want.mean_fixed)
                        report_mismatch("mean_fixed", 64'(o_mean_fixed),
                                        64'(want.mean_fixed));
                    if (o_sigma_fixed !== want.sigma_fixed)
                        report_mismatch("sigma_fixed", 64'(o_sigma_fixed),
                                        64'(want.sigma_fixed));
                end
            end
        end
    end

endmodule

// ===== tb/pedestal_threshold_from_moments_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the pedestal/threshold block.
module pedestal_threshold_from_moments_tb;
    import ptfm_pkg::*;

    localparam int LATENCY  = 97;
    localparam int WD_LIMIT = 3000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [23:0]            i_sample_count;
    logic [35:0]            i_charge_sum;
    logic [47:0]            i_square_sum;
    logic                   o_done;
    logic [2*HALF_BITS-1:0] o_packed_word;
    logic [FIELD_BITS-1:0]  o_mean_fixed;
    logic [FIELD_BITS-1:0]  o_sigma_fixed;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CUT_BITS-1:0]    i_cfg_data;
    int                     fail_count;
    int                     pending;
    int                     idle_pct;
    int                     quiet_cycles;

    pedestal_threshold_from_moments u_top (.*);

    pedestal_threshold_from_moments_checker u_chk (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("** pedestal_threshold_from_moments: FAILED **");
            $finish;
        end
    end

    task automatic send_channel(input logic [23:0] n, input logic [35:0] s,
                                input logic [47:0] q);
        logic ok;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sample_count <= n;
        i_charge_sum   <= s;
        i_square_sum   <= q;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // hold off until every expected result is back, then let the pipe drain
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_cut(input logic [CUT_BITS-1:0] val);
        logic ok;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly plausible moments of 12-bit samples; some raw noise and edge counts
    task automatic send_random();
        logic [63:0] n, mu, sd, s, q;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 15) begin
            send_channel(24'($urandom), {4'($urandom), 32'($urandom)},
                         {16'($urandom), 32'($urandom)});
        end else begin
            case ($urandom_range(3))
                0: n = $urandom_range(1, 16);
                1: n = $urandom_range(1, 4000);
                2: n = $urandom_range(1, 1 << 20);
                default: n = (kind < 20) ? 0 : 64'($urandom_range(24'hFFFFFF));
            endcase
            mu = $urandom_range(4095);
            sd = $urandom_range(0, (kind < 60) ? 30 : 600);
            s  = n * mu + $urandom_range(0, 255);
            q  = n * (mu * mu + sd * sd) + $urandom_range(0, 4095);
            send_channel(n[23:0], s[35:0], q[47:0]);
        end
    endtask

    initial begin
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_sample_count = '0;
        i_charge_sum   = '0;
        i_square_sum   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        idle_pct       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed channels at the reset cut of 4.0
        send_channel(24'd0, 36'd12345, 48'd999);
        send_channel(24'd0, '1, '1);
        send_channel(24'd1, 36'd0, 48'd0);
        send_channel(24'd1, 36'd4095, 48'd16769025);
        send_channel(24'd1, 36'd4095, 48'd0);           // negative variance
        send_channel('1, '1, '1);
        send_channel('1, 36'd0, '1);
        send_channel('1, '1, 48'd0);
        send_channel(24'd1, '1, '1);
        send_channel(24'd100, 36'd20000, 48'd4010000);
        send_channel(24'd1000, 36'd600000, 48'd362250000);
        send_channel(24'd2, 36'd3, 48'd5);
        send_channel(24'd3, 36'd1000, 48'd0);
        send_channel(24'd7, 36'd511, 48'd37303);
        send_channel(24'd4096, 36'd16773120, 48'd68685926400);
        drain();

        idle_pct = 27;
        write_cut(16'd0);
        for (int i = 0; i < 600; i++) send_random();
        drain();

        idle_pct = 80;
        write_cut(16'hFFFF);
        send_channel('1, 36'd0, '1);
        for (int i = 0; i < 600; i++) send_random();
        drain();

        idle_pct = 0;
        write_cut(16'h0100);
        for (int i = 0; i < 300; i++) send_random();
        drain();
        write_cut(16'($urandom));
        for (int i = 0; i < 300; i++) send_random();
        drain();

        if (fail_count == 0)
            $display("** pedestal_threshold_from_moments: PASSED **");
        else
            $display("** pedestal_threshold_from_moments: FAILED **");
        $finish;
    end

endmodule
